FILE: hw/rtl/mpbm_pkg.sv
// ----------------------------------------------------------------------------
// Price broadcast master package
// Beat types, codes, frame constants and the CRC-16 byte step shared by the
// price broadcast master and its checker.
// ----------------------------------------------------------------------------
package mpbm_pkg;

    localparam int PRICES    = 24;
    localparam int PRICE_AW  = 5;
    localparam int HDR_LEN   = 7;
    localparam int FRAME_LEN = 57;

    localparam logic [15:0] CRC_INIT      = 16'hFFFF;
    localparam logic [15:0] CRC_POLY      = 16'hA001;
    localparam logic [15:0] TIMEOUT_RESET = 16'd40;

    localparam logic [7:0] FC_WRITE_MULTI = 8'h10;
    localparam logic [7:0] REG_COUNT      = 8'h18;
    localparam logic [7:0] BYTE_COUNT     = 8'h30;

    typedef enum logic [1:0] {
        OP_LOAD  = 2'd0,
        OP_START = 2'd1,
        OP_RX    = 2'd2,
        OP_TICK  = 2'd3
    } t_op;

    typedef enum logic [1:0] {
        KIND_TX      = 2'd0,
        KIND_OUTCOME = 2'd1,
        KIND_DONE    = 2'd2
    } t_kind;

    typedef enum logic [1:0] {
        ST_NONE    = 2'd0,
        ST_PENDING = 2'd1,
        ST_FAILED  = 2'd2,
        ST_ACKED   = 2'd3
    } t_status;

    typedef struct packed {
        t_op         op;
        logic [4:0]  slot;
        logic [7:0]  slave_id;
        logic [15:0] price;
        logic [7:0]  rx_byte;
    } t_in;

    typedef struct packed {
        t_kind       kind;
        logic [7:0]  tx_byte;
        logic [4:0]  done_slot;
        t_status     slot_status;
        logic        last;
    } t_out;

    // Modbus CRC-16, reflected polynomial, one byte.
    function automatic logic [15:0] crc_byte(input logic [15:0] crc, input logic [7:0] b);
        logic [15:0] c;
        c = crc ^ {8'h00, b};
        for (int k = 0; k < 8; k++) begin
            c = c[0] ? ((c >> 1) ^ CRC_POLY) : (c >> 1);
        end
        return c;
    endfunction

    // Price word w of the frame maps to a table entry. The first sixteen words
    // interleave positions one and two of each screen, the last eight carry
    // position three.
    function automatic logic [4:0] price_entry(input logic [4:0] w);
        logic [2:0] s;
        logic [4:0] e;
        if (w < 5'd16) begin
            s = w[3:1];
            e = 5'({s, 1'b0}) + 5'(s) + 5'(w[0]);
        end else begin
            s = w[2:0];
            e = 5'({s, 1'b0}) + 5'(s) + 5'd2;
        end
        return e;
    endfunction

endpackage

FILE: hw/rtl/mpbm_ram.sv
// ----------------------------------------------------------------------------
// Generic single-port-write RAM
// One write port and one read port with registered read data.
// ----------------------------------------------------------------------------
module mpbm_ram #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 24
) (
    input  logic                                    i_clk,
    input  logic                                    i_we,
    input  logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] i_waddr,
    input  logic [WIDTH-1:0]                        i_wdata,
    input  logic                                    i_re,
    input  logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] i_raddr,
    output logic [WIDTH-1:0]                        o_rdata
);

    logic [WIDTH-1:0] r_mem [DEPTH];
    logic [WIDTH-1:0] r_rdata;

    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
        if (i_re) begin
            r_rdata <= r_mem[i_raddr];
        end
    end

    assign o_rdata = r_rdata;

endmodule

FILE: hw/rtl/mpbm_table.sv
// ----------------------------------------------------------------------------
// Zero-initialized table
// RAM plus one valid bit per entry so that entries never loaded read as zero
// after reset. Read data shows in the cycle after the read enable and holds.
// ----------------------------------------------------------------------------
module mpbm_table #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 24
) (
    input  logic                                    i_clk,
    input  logic                                    i_rst_n,
    input  logic                                    i_we,
    input  logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] i_waddr,
    input  logic [WIDTH-1:0]                        i_wdata,
    input  logic                                    i_re,
    input  logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] i_raddr,
    output logic [WIDTH-1:0]                        o_rdata
);

    logic [DEPTH-1:0] r_vld;
    logic             r_rd_vld;
    logic [WIDTH-1:0] ram_rdata;

    mpbm_ram #(
        .WIDTH (WIDTH),
        .DEPTH (DEPTH)
    ) u_ram (
        .i_clk   (i_clk),
        .i_we    (i_we),
        .i_waddr (i_waddr),
        .i_wdata (i_wdata),
        .i_re    (i_re),
        .i_raddr (i_raddr),
        .o_rdata (ram_rdata)
    );

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_vld    <= '0;
            r_rd_vld <= 1'b0;
        end else begin
            if (i_we) begin
                r_vld[i_waddr] <= 1'b1;
            end
            if (i_re) begin
                r_rd_vld <= r_vld[i_raddr];
            end
        end
    end

    assign o_rdata = r_rd_vld ? ram_rdata : '0;

endmodule

FILE: hw/rtl/modbus_price_broadcast_master.sv
// A start, or a reply byte or tick that ends a slot, walks the slave table and
// then streams the 57-byte frame to the next used slave at one beat per cycle
// while the output is not stalled; the table walk and the frame streamer share
// one read port per table, so one item is in work at a time.
// Reset is synchronous; both tables read as zero and the timeout is 40.
// ----------------------------------------------------------------------------
// Modbus RTU price broadcast master
// Scans the slave table, sends a write-multiple-registers frame to each used
// slave and checks the eight-byte reply, reporting one outcome per used slot.
// ----------------------------------------------------------------------------
module modbus_price_broadcast_master #(
    parameter int SLOTS = 24
) (
    input  logic           i_clk,
    input  logic           i_rst_n,
    input  logic           i_in_valid,
    output logic           o_in_ready,
    input  mpbm_pkg::t_in  i_in,
    output logic           o_out_valid,
    input  logic           i_out_ready,
    output mpbm_pkg::t_out o_out,
    input  logic           i_cfg_we,
    input  logic [15:0]    i_cfg_wdata
);

    import mpbm_pkg::*;

    localparam int SAW = (SLOTS > 1) ? $clog2(SLOTS) : 1;
    localparam int PW  = $clog2(SLOTS + 1);

    typedef enum logic [2:0] {
        S_IDLE,
        S_RXCMP,
        S_OUTCOME,
        S_SKIP,
        S_SKIPCHK,
        S_HDR,
        S_PRICE,
        S_CRC
    } t_state;

    t_state      r_state, n_state;
    logic        r_active, n_active;
    logic [PW-1:0] r_ptr, n_ptr;
    logic [3:0]  r_cnt, n_cnt;
    logic [15:0] r_rcrc, n_rcrc;
    logic        r_lowok, n_lowok;
    logic [15:0] r_idle, n_idle;
    logic [15:0] r_tmo, n_tmo;
    logic [7:0]  r_rx, n_rx;
    t_status     r_status, n_status;
    logic [5:0]  r_idx, n_idx;
    logic [4:0]  r_w, n_w;
    logic [15:0] r_fcrc, n_fcrc;
    logic        r_ov, n_ov;
    t_out        r_out, n_out;

    logic              accept;
    logic              out_free;
    logic              emit;
    t_out              beat;
    logic [15:0]       idle_inc;
    logic [7:0]        fbyte;
    logic [4:0]        rd_w;

    logic              slave_we, slave_re;
    logic [7:0]        slave_rdata;
    logic              price_we, price_re;
    logic [15:0]       price_rdata;

    function automatic logic [7:0] hdr_byte(input logic [5:0] idx, input logic [7:0] sid);
        logic [7:0] b;
        case (idx)
            6'd0:    b = sid;
            6'd1:    b = FC_WRITE_MULTI;
            6'd5:    b = REG_COUNT;
            6'd6:    b = BYTE_COUNT;
            default: b = 8'h00;
        endcase
        return b;
    endfunction

    mpbm_table #(
        .WIDTH (8),
        .DEPTH (SLOTS)
    ) u_slave (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_we    (slave_we),
        .i_waddr (i_in.slot[SAW-1:0]),
        .i_wdata (i_in.slave_id),
        .i_re    (slave_re),
        .i_raddr (r_ptr[SAW-1:0]),
        .o_rdata (slave_rdata)
    );

    mpbm_table #(
        .WIDTH (16),
        .DEPTH (PRICES)
    ) u_price (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_we    (price_we),
        .i_waddr (i_in.slot[PRICE_AW-1:0]),
        .i_wdata (i_in.price),
        .i_re    (price_re),
        .i_raddr (price_entry(rd_w)),
        .o_rdata (price_rdata)
    );

    assign o_in_ready  = (r_state == S_IDLE);
    assign accept      = i_in_valid && o_in_ready;
    assign out_free    = !r_ov || i_out_ready;
    assign o_out_valid = r_ov;
    assign o_out       = r_out;
    assign idle_inc    = (r_idle == 16'hFFFF) ? r_idle : r_idle + 16'd1;

    always_comb begin
        n_state  = r_state;
        n_active = r_active;
        n_ptr    = r_ptr;
        n_cnt    = r_cnt;
        n_rcrc   = r_rcrc;
        n_lowok  = r_lowok;
        n_idle   = r_idle;
        n_tmo    = i_cfg_we ? i_cfg_wdata : r_tmo;
        n_rx     = r_rx;
        n_status = r_status;
        n_idx    = r_idx;
        n_w      = r_w;
        n_fcrc   = r_fcrc;
        n_out    = r_out;
        slave_we = 1'b0;
        slave_re = 1'b0;
        price_we = 1'b0;
        price_re = 1'b0;
        rd_w     = r_w;
        emit     = 1'b0;
        beat     = '0;
        fbyte    = 8'h00;

        case (r_state)
            S_IDLE: begin
                if (accept) begin
                    case (i_in.op)
                        OP_LOAD: begin
                            slave_we = (i_in.slot < 5'(SLOTS));
                            price_we = (i_in.slot < 5'(PRICES));
                        end
                        OP_START: begin
                            n_active = 1'b1;
                            n_ptr    = '0;
                            n_state  = S_SKIP;
                        end
                        OP_RX: begin
                            if (r_active) begin
                                n_idle = '0;
                                n_rx   = i_in.rx_byte;
                                if (r_cnt == 4'd0) begin
                                    // First byte must match the slave id now in the table.
                                    slave_re = 1'b1;
                                    n_state  = S_RXCMP;
                                end else if (r_cnt < 4'd6) begin
                                    n_rcrc = crc_byte(r_rcrc, i_in.rx_byte);
                                    n_cnt  = r_cnt + 4'd1;
                                end else if (r_cnt == 4'd6) begin
                                    n_lowok = (i_in.rx_byte == r_rcrc[7:0]);
                                    n_cnt   = 4'd7;
                                end else begin
                                    n_status = (r_lowok && i_in.rx_byte == r_rcrc[15:8]) ?
                                               ST_ACKED : ST_FAILED;
                                    n_cnt    = 4'd8;
                                    n_state  = S_OUTCOME;
                                end
                            end
                        end
                        OP_TICK: begin
                            if (r_active) begin
                                n_idle = idle_inc;
                                if (idle_inc > r_tmo) begin
                                    n_status = ST_FAILED;
                                    n_state  = S_OUTCOME;
                                end
                            end
                        end
                        default: ;
                    endcase
                end
            end
            S_RXCMP: begin
                if (r_rx == slave_rdata) begin
                    n_rcrc = crc_byte(CRC_INIT, r_rx);
                    n_cnt  = 4'd1;
                end
                n_state = S_IDLE;
            end
            S_OUTCOME: begin
                if (out_free) begin
                    emit             = 1'b1;
                    beat.kind        = KIND_OUTCOME;
                    beat.done_slot   = 5'(r_ptr);
                    beat.slot_status = r_status;
                    n_ptr            = PW'(r_ptr + 1'b1);
                    n_state          = S_SKIP;
                end
            end
            S_SKIP: begin
                if (r_ptr < PW'(SLOTS)) begin
                    slave_re = 1'b1;
                    n_state  = S_SKIPCHK;
                end else if (out_free) begin
                    emit      = 1'b1;
                    beat.kind = KIND_DONE;
                    beat.last = 1'b1;
                    n_active  = 1'b0;
                    n_state   = S_IDLE;
                end
            end
            S_SKIPCHK: begin
                if (slave_rdata == 8'h00) begin
                    n_ptr   = PW'(r_ptr + 1'b1);
                    n_state = S_SKIP;
                end else begin
                    n_cnt   = '0;
                    n_rcrc  = CRC_INIT;
                    n_lowok = 1'b0;
                    n_idle  = '0;
                    n_idx   = '0;
                    n_w     = '0;
                    n_fcrc  = CRC_INIT;
                    n_state = S_HDR;
                end
            end
            S_HDR: begin
                fbyte = hdr_byte(r_idx, slave_rdata);
                if (out_free) begin
                    emit         = 1'b1;
                    beat.tx_byte = fbyte;
                    n_fcrc       = crc_byte(r_fcrc, fbyte);
                    n_idx        = r_idx + 6'd1;
                    if (r_idx == 6'(HDR_LEN - 1)) begin
                        // Fetch the first price word while the byte count goes out.
                        price_re = 1'b1;
                        rd_w     = '0;
                        n_state  = S_PRICE;
                    end
                end
            end
            S_PRICE: begin
                // Price bytes start at an odd position, so odd positions carry the high byte.
                fbyte = r_idx[0] ? price_rdata[15:8] : price_rdata[7:0];
                if (out_free) begin
                    emit         = 1'b1;
                    beat.tx_byte = fbyte;
                    n_fcrc       = crc_byte(r_fcrc, fbyte);
                    n_idx        = r_idx + 6'd1;
                    if (!r_idx[0]) begin
                        if (r_w == 5'(PRICES - 1)) begin
                            n_state = S_CRC;
                        end else begin
                            n_w      = r_w + 5'd1;
                            rd_w     = r_w + 5'd1;
                            price_re = 1'b1;
                        end
                    end
                end
            end
            S_CRC: begin
                fbyte = r_idx[0] ? r_fcrc[7:0] : r_fcrc[15:8];
                if (out_free) begin
                    emit         = 1'b1;
                    beat.tx_byte = fbyte;
                    beat.last    = !r_idx[0];
                    n_idx        = r_idx + 6'd1;
                    if (r_idx == 6'(FRAME_LEN - 1)) begin
                        n_state = S_IDLE;
                    end
                end
            end
            default: n_state = S_IDLE;
        endcase

        if (emit) begin
            n_ov  = 1'b1;
            n_out = beat;
        end else if (i_out_ready) begin
            n_ov = 1'b0;
        end else begin
            n_ov = r_ov;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state  <= S_IDLE;
            r_active <= 1'b0;
            r_ptr    <= '0;
            r_cnt    <= '0;
            r_rcrc   <= CRC_INIT;
            r_lowok  <= 1'b0;
            r_idle   <= '0;
            r_tmo    <= TIMEOUT_RESET;
            r_ov     <= 1'b0;
        end else begin
            r_state  <= n_state;
            r_active <= n_active;
            r_ptr    <= n_ptr;
            r_cnt    <= n_cnt;
            r_rcrc   <= n_rcrc;
            r_lowok  <= n_lowok;
            r_idle   <= n_idle;
            r_tmo    <= n_tmo;
            r_ov     <= n_ov;
        end
        r_rx     <= n_rx;
        r_status <= n_status;
        r_idx    <= n_idx;
        r_w      <= n_w;
        r_fcrc   <= n_fcrc;
        r_out    <= n_out;
    end

endmodule

FILE: hw/rtl/mpbm_chk.sv
// ----------------------------------------------------------------------------
// Price broadcast master port checker
// Watches the top-level ports for beat formatting and sequencing errors.
// ----------------------------------------------------------------------------
module mpbm_chk (
    input logic           i_clk,
    input logic           i_rst_n,
    input logic           i_in_valid,
    input logic           o_in_ready,
    input mpbm_pkg::t_in  i_in,
    input logic           o_out_valid,
    input logic           i_out_ready,
    input mpbm_pkg::t_out o_out
);

    import mpbm_pkg::*;

    // A stalled result beat keeps its contents.
    a_out_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_out_valid && !i_out_ready |=> o_out_valid && $stable(o_out))
        else $error("result beat changed while stalled");

    // A slot outcome is never the final beat and reports a finished status.
    a_outcome_form: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_out_valid && o_out.kind == KIND_OUTCOME |->
            !o_out.last && o_out.tx_byte == 8'h00 &&
            (o_out.slot_status == ST_FAILED || o_out.slot_status == ST_ACKED))
        else $error("malformed slot outcome beat");

    // The scan-finished beat always closes the work of its input item.
    a_done_form: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_out_valid && o_out.kind == KIND_DONE |->
            o_out.last && o_out.done_slot == 5'd0 && o_out.slot_status == ST_NONE)
        else $error("malformed scan finished beat");

    // A start always produces results, so the input side is busy right after it.
    a_start_busy: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_in_valid && o_in_ready && i_in.op == OP_START |=> !o_in_ready)
        else $error("input taken right after a start");

endmodule

bind modbus_price_broadcast_master mpbm_chk u_mpbm_chk (.*);
